/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/vcva_pkg.sv */
// Package: constants, types, address and dimension-clamp helpers for the cell-to-vertex averager.
`timescale 1ns / 1ps

package vcva_pkg;

   localparam int MAX_DIM_X = 64;
   localparam int MAX_DIM_Y = 64;
   localparam int MAX_DIM_Z = 64;

   localparam int PX_W = (MAX_DIM_X > 1) ? $clog2(MAX_DIM_X) : 1;
   localparam int PY_W = (MAX_DIM_Y > 1) ? $clog2(MAX_DIM_Y) : 1;
   localparam int PZ_W = (MAX_DIM_Z > 1) ? $clog2(MAX_DIM_Z) : 1;

   localparam int PLANE_CELLS = MAX_DIM_X * MAX_DIM_Y;
   localparam int STORE_DEPTH = 2 * PLANE_CELLS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int DENS_W = 16;
   localparam int DIM_W  = 7;
   localparam int VTX_W  = 7;
   localparam int T_W    = DIM_W + 1;
   localparam int SUM_W  = DENS_W + 3;
   localparam int CNT_W  = 4;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctrl_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
   } ram_ctrl_type;

   function automatic logic [ADDR_W-1:0] plane_addr(
      input logic            zpar,
      input logic [PY_W-1:0] y,
      input logic [PX_W-1:0] x
   );
      logic [ADDR_W-1:0] base;
      base = zpar ? ADDR_W'(PLANE_CELLS) : '0;
      return base + ADDR_W'(y) * ADDR_W'(MAX_DIM_X) + ADDR_W'(x);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(
      input logic [CSR_DAT_W-1:0] v,
      input int                   maxd
   );
      logic [DIM_W-1:0] d;
      d = DIM_W'(v);
      if (d == '0) begin
         d = DIM_W'(1);
      end
      if (32'(d) > maxd) begin
         d = DIM_W'(maxd);
      end
      return d;
   endfunction

endpackage

/* rtl/vcva_plane_ram.sv */
// Single-port plane store with registered read data.
`timescale 1ns / 1ps

module vcva_plane_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/vcva_accum.sv */
// Shared accumulator: sums neighbor densities and forms the floor mean.
`timescale 1ns / 1ps

module vcva_accum (
   input  logic                         clock,
   input  vcva_pkg::acc_ctrl_type       ctrl,
   input  logic signed [vcva_pkg::DENS_W-1:0] rd_data,
   output logic signed [vcva_pkg::DENS_W-1:0] mean
);
   import vcva_pkg::*;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [1:0]              shift;
   logic signed [SUM_W-1:0] shifted;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         sum_in   = '0;
         count_in = '0;
      end else if (ctrl.add) begin
         sum_in   = sum_ff + SUM_W'(rd_data);
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      count_ff <= count_in;
   end

   always_comb begin
      priority if (count_ff >= CNT_W'(8)) begin
         shift = 2'd3;
      end else if (count_ff >= CNT_W'(4)) begin
         shift = 2'd2;
      end else if (count_ff >= CNT_W'(2)) begin
         shift = 2'd1;
      end else begin
         shift = 2'd0;
      end
      shifted = sum_ff >>> shift;
      mean    = shifted[DENS_W-1:0];
   end

endmodule

/* rtl/vcva_seq.sv */
// Sequencer: registers, cell position, vertex and neighbor stepping.
`timescale 1ns / 1ps

module vcva_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_first_cell,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [vcva_pkg::VTX_W-1:0]       rsp_vertex_x,
   output logic [vcva_pkg::VTX_W-1:0]       rsp_vertex_y,
   output logic [vcva_pkg::VTX_W-1:0]       rsp_vertex_z,
   output logic                             rsp_last_of_run,
   input  logic                             csr_we,
   input  logic [vcva_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vcva_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output vcva_pkg::ram_ctrl_type           ram_ctrl,
   output vcva_pkg::acc_ctrl_type           acc_ctrl
);
   import vcva_pkg::*;

   state_type state_ff, state_in;

   logic [DIM_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic             enable_ff;

   logic [PX_W-1:0] pos_x_ff, pos_x_in, cur_x_ff, cur_x_in;
   logic [PY_W-1:0] pos_y_ff, pos_y_in, cur_y_ff, cur_y_in;
   logic [PZ_W-1:0] pos_z_ff, pos_z_in, cur_z_ff, cur_z_in;
   logic            lx_ff, lx_in, ly_ff, ly_in, lz_ff, lz_in;
   logic            ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic [2:0]      slot_ff, slot_in;
   logic            pend_ff, pend_in;

   logic            accept;
   logic [PX_W-1:0] ex;
   logic [PY_W-1:0] ey;
   logic [PZ_W-1:0] ez;
   logic [DIM_W-1:0] ex1, ey1, ez1;
   logic [T_W-1:0]  tx, ty, tz;
   logic [T_W-1:0]  cx, cy, cz;
   logic            cell_ok;
   logic            last_vtx;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff  <= DIM_W'(1);
         dim_y_ff  <= DIM_W'(1);
         dim_z_ff  <= DIM_W'(1);
         enable_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIM_X:  dim_x_ff  <= clamp_dim(csr_wdata, MAX_DIM_X);
            CSR_DIM_Y:  dim_y_ff  <= clamp_dim(csr_wdata, MAX_DIM_Y);
            CSR_DIM_Z:  dim_z_ff  <= clamp_dim(csr_wdata, MAX_DIM_Z);
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective position of the incoming cell.
   always_comb begin
      ex = pos_x_ff;
      ey = pos_y_ff;
      ez = pos_z_ff;
      if (req_first_cell) begin
         ex = '0;
         ey = '0;
         ez = '0;
      end
      if (DIM_W'(ex) >= dim_x_ff) begin
         ex = '0;
      end
      if (DIM_W'(ey) >= dim_y_ff) begin
         ey = '0;
      end
      if (DIM_W'(ez) >= dim_z_ff) begin
         ez = '0;
      end
      ex1 = DIM_W'(ex) + DIM_W'(1);
      ey1 = DIM_W'(ey) + DIM_W'(1);
      ez1 = DIM_W'(ez) + DIM_W'(1);
   end

   // Neighbor cell of the current vertex selected by the slot.
   always_comb begin
      tx = T_W'(cur_x_ff) + T_W'(ix_ff) + T_W'(slot_ff[0]);
      ty = T_W'(cur_y_ff) + T_W'(iy_ff) + T_W'(slot_ff[1]);
      tz = T_W'(cur_z_ff) + T_W'(iz_ff) + T_W'(slot_ff[2]);
      cx = tx - T_W'(1);
      cy = ty - T_W'(1);
      cz = tz - T_W'(1);
      cell_ok = (tx != '0) && (cx < T_W'(dim_x_ff))
             && (ty != '0) && (cy < T_W'(dim_y_ff))
             && (tz != '0) && (cz < T_W'(dim_z_ff));
      last_vtx = (ix_ff == lx_ff) && (iy_ff == ly_ff) && (iz_ff == lz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      cur_z_ff <= cur_z_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      lz_ff    <= lz_in;
      ix_ff    <= ix_in;
      iy_ff    <= iy_in;
      iz_ff    <= iz_in;
      slot_ff  <= slot_in;
   end

   always_comb begin
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_z_in = cur_z_ff;
      lx_in    = lx_ff;
      ly_in    = ly_ff;
      lz_in    = lz_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      iz_in    = iz_ff;
      slot_in  = slot_ff;
      pend_in  = 1'b0;
      accept   = 1'b0;

      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      ram_ctrl.we   = 1'b0;
      ram_ctrl.re   = 1'b0;
      ram_ctrl.addr = plane_addr(cz[0], cy[PY_W-1:0], cx[PX_W-1:0]);
      acc_ctrl.clear = 1'b0;
      acc_ctrl.add   = pend_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            accept        = req_valid;
            ram_ctrl.addr = plane_addr(ez[0], ey, ex);
            if (accept) begin
               ram_ctrl.we = 1'b1;
               cur_x_in = ex;
               cur_y_in = ey;
               cur_z_in = ez;
               lx_in    = (ex1 == dim_x_ff);
               ly_in    = (ey1 == dim_y_ff);
               lz_in    = (ez1 == dim_z_ff);
               ix_in    = 1'b0;
               iy_in    = 1'b0;
               iz_in    = 1'b0;
               slot_in  = '0;
               // advance raster position
               pos_x_in = PX_W'(ex1);
               pos_y_in = ey;
               pos_z_in = ez;
               if (ex1 >= dim_x_ff) begin
                  pos_x_in = '0;
                  pos_y_in = PY_W'(ey1);
                  if (ey1 >= dim_y_ff) begin
                     pos_y_in = '0;
                     pos_z_in = PZ_W'(ez1);
                     if (ez1 >= dim_z_ff) begin
                        pos_z_in = '0;
                     end
                  end
               end
               if (enable_ff) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_ctrl.re    = 1'b1;
            pend_in        = cell_ok;
            acc_ctrl.clear = (slot_ff == '0);
            slot_in        = slot_ff + 3'd1;
            if (slot_ff == 3'd7) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               slot_in = '0;
               if (last_vtx) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
                  if (lx_ff && !ix_ff) begin
                     ix_in = 1'b1;
                  end else begin
                     ix_in = 1'b0;
                     if (ly_ff && !iy_ff) begin
                        iy_in = 1'b1;
                     end else begin
                        iy_in = 1'b0;
                        iz_in = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_vertex_x    = VTX_W'(cur_x_ff) + VTX_W'(ix_ff);
   assign rsp_vertex_y    = VTX_W'(cur_y_ff) + VTX_W'(iy_ff);
   assign rsp_vertex_z    = VTX_W'(cur_z_ff) + VTX_W'(iz_ff);
   assign rsp_last_of_run = last_vtx;

endmodule

/* rtl/voxel_cell_to_vertex_average.sv */
// Top level: streamed voxel cell to lattice vertex box average.
// A cell that causes no vertex (output disabled) is taken without leaving idle;
// otherwise each vertex takes 8 neighbor reads through the single store port,
// a drain and a handover, plus rsp stalls; interior cells give 1 vertex, corners up to 8.
// Synchronous active-high reset clears the sequencer and position, sets dims to 1
// and enable to 1; the plane store is not cleared.
`timescale 1ns / 1ps

module voxel_cell_to_vertex_average (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [vcva_pkg::DENS_W-1:0]    req_cell_density,
   input  logic                                  req_first_cell,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vcva_pkg::VTX_W-1:0]            rsp_vertex_x,
   output logic [vcva_pkg::VTX_W-1:0]            rsp_vertex_y,
   output logic [vcva_pkg::VTX_W-1:0]            rsp_vertex_z,
   output logic signed [vcva_pkg::DENS_W-1:0]    rsp_vertex_density,
   output logic                                  rsp_last_of_run,
   input  logic                                  csr_we,
   input  logic [vcva_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vcva_pkg::CSR_DAT_W-1:0]        csr_wdata
);
   import vcva_pkg::*;

   ram_ctrl_type       ram_ctrl;
   acc_ctrl_type       acc_ctrl;
   logic [DENS_W-1:0]  rd_data;

   vcva_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_cell  (req_first_cell),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_vertex_z    (rsp_vertex_z),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .ram_ctrl        (ram_ctrl),
      .acc_ctrl        (acc_ctrl)
   );

   vcva_plane_ram #(
      .WIDTH (DENS_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_ctrl.we),
      .re    (ram_ctrl.re),
      .addr  (ram_ctrl.addr),
      .wdata (req_cell_density),
      .rdata (rd_data)
   );

   vcva_accum u_accum (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .rd_data (rd_data),
      .mean    (rsp_vertex_density)
   );

endmodule

/* rtl/vcva_checker.sv */
// Port-level checker for the cell-to-vertex averager, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vcva_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [vcva_pkg::VTX_W-1:0]         rsp_vertex_x,
   input logic [vcva_pkg::VTX_W-1:0]         rsp_vertex_y,
   input logic [vcva_pkg::VTX_W-1:0]         rsp_vertex_z,
   input logic [vcva_pkg::DENS_W-1:0]        rsp_vertex_density,
   input logic                               rsp_last_of_run
);

   `ASSERT_CLK_ALWAYS(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "not idle after reset")
   `ASSERT_CLK(a_one_item, clock, reset, !(req_ready && rsp_valid), "input taken while result pending")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_vertex_x, rsp_vertex_y, rsp_vertex_z, rsp_vertex_density, rsp_last_of_run})), "stalled result changed")
   `ASSERT_CLK(a_run_end, clock, reset, (rsp_valid && rsp_ready && rsp_last_of_run) |=> (req_ready && !rsp_valid), "no return to idle after last vertex")

endmodule

bind voxel_cell_to_vertex_average vcva_checker u_vcva_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_vertex_x       (rsp_vertex_x),
   .rsp_vertex_y       (rsp_vertex_y),
   .rsp_vertex_z       (rsp_vertex_z),
   .rsp_vertex_density (rsp_vertex_density),
   .rsp_last_of_run    (rsp_last_of_run)
);

/* verif/vertex_average_checker.sv */
// Checker: predicts the vertex averages of every accepted cell and compares each vertex item.
`timescale 1ns / 1ps

module vertex_average_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [vcva_pkg::DENS_W-1:0]  req_cell_density,
   input  logic                                req_first_cell,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [vcva_pkg::VTX_W-1:0]          rsp_vertex_x,
   input  logic [vcva_pkg::VTX_W-1:0]          rsp_vertex_y,
   input  logic [vcva_pkg::VTX_W-1:0]          rsp_vertex_z,
   input  logic signed [vcva_pkg::DENS_W-1:0]  rsp_vertex_density,
   input  logic                                rsp_last_of_run,
   input  logic                                csr_we,
   input  logic [vcva_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vcva_pkg::CSR_DAT_W-1:0]      csr_wdata,
   output int                                  mismatch_count,
   output int                                  vertices_due
);

   localparam int REPORT_LIMIT = 100;

   typedef struct {
      logic [vcva_pkg::VTX_W-1:0]         vx;
      logic [vcva_pkg::VTX_W-1:0]         vy;
      logic [vcva_pkg::VTX_W-1:0]         vz;
      logic signed [vcva_pkg::DENS_W-1:0] density;
      logic                               last;
   } vertex_item_type;

   vertex_item_type expected_vertices[$];

   logic signed [vcva_pkg::DENS_W-1:0] cell_plane [0:vcva_pkg::STORE_DEPTH-1];

   int   dim_x = 1;
   int   dim_y = 1;
   int   dim_z = 1;
   logic enabled = 1'b1;
   int   cur_x = 0;
   int   cur_y = 0;
   int   cur_z = 0;
   int   errs = 0;

   function automatic int effective_dim(input logic [vcva_pkg::CSR_DAT_W-1:0] v,
                                        input int limit);
      int d;
      d = int'(v);
      if (d == 0) begin
         d = 1;
      end
      if (d > limit) begin
         d = limit;
      end
      return d;
   endfunction

   function automatic int store_index(input int x, input int y, input int z);
      return (z & 1) * vcva_pkg::PLANE_CELLS + y * vcva_pkg::MAX_DIM_X + x;
   endfunction

   function automatic logic signed [vcva_pkg::DENS_W-1:0] vertex_floor_mean(
      input int vx,
      input int vy,
      input int vz
   );
      int sum;
      int count;
      int sh;
      int cx;
      int cy;
      int cz;
      sum   = 0;
      count = 0;
      for (int dz = 0; dz < 2; dz++) begin
         cz = vz + dz - 1;
         if (cz < 0 || cz >= dim_z) continue;
         for (int dy = 0; dy < 2; dy++) begin
            cy = vy + dy - 1;
            if (cy < 0 || cy >= dim_y) continue;
            for (int dx = 0; dx < 2; dx++) begin
               cx = vx + dx - 1;
               if (cx < 0 || cx >= dim_x) continue;
               sum += int'(cell_plane[store_index(cx, cy, cz)]);
               count++;
            end
         end
      end
      sh = (count >= 8) ? 3 : (count >= 4) ? 2 : (count >= 2) ? 1 : 0;
      return vcva_pkg::DENS_W'(sum >>> sh);
   endfunction

   task automatic predict_vertices(input logic signed [vcva_pkg::DENS_W-1:0] dens,
                                   input logic first);
      int nx;
      int ny;
      int nz;
      vertex_item_type v;
      if (first) begin
         cur_x = 0;
         cur_y = 0;
         cur_z = 0;
      end
      if (cur_x >= dim_x) cur_x = 0;
      if (cur_y >= dim_y) cur_y = 0;
      if (cur_z >= dim_z) cur_z = 0;
      cell_plane[store_index(cur_x, cur_y, cur_z)] = dens;
      if (enabled) begin
         nx = (cur_x + 1 == dim_x) ? 2 : 1;
         ny = (cur_y + 1 == dim_y) ? 2 : 1;
         nz = (cur_z + 1 == dim_z) ? 2 : 1;
         for (int iz = 0; iz < nz; iz++) begin
            for (int iy = 0; iy < ny; iy++) begin
               for (int ix = 0; ix < nx; ix++) begin
                  v.vx      = vcva_pkg::VTX_W'(cur_x + ix);
                  v.vy      = vcva_pkg::VTX_W'(cur_y + iy);
                  v.vz      = vcva_pkg::VTX_W'(cur_z + iz);
                  v.density = vertex_floor_mean(cur_x + ix, cur_y + iy, cur_z + iz);
                  v.last    = (iz == nz - 1) && (iy == ny - 1) && (ix == nx - 1);
                  expected_vertices.push_back(v);
               end
            end
         end
      end
      cur_x++;
      if (cur_x >= dim_x) begin
         cur_x = 0;
         cur_y++;
         if (cur_y >= dim_y) begin
            cur_y = 0;
            cur_z++;
            if (cur_z >= dim_z) cur_z = 0;
         end
      end
   endtask

   task automatic compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         errs++;
         if (errs <= REPORT_LIMIT) begin
            $display("%0t: vertex %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
         end
      end
   endtask

   task automatic check_vertex();
      vertex_item_type v;
      if (expected_vertices.size() == 0) begin
         errs++;
         if (errs <= REPORT_LIMIT) begin
            $display("%0t: unexpected vertex, expected none, actual (%0d,%0d,%0d) %0d",
                     $time, rsp_vertex_x, rsp_vertex_y, rsp_vertex_z, rsp_vertex_density);
         end
      end else begin
         v = expected_vertices.pop_front();
         compare_field("x", v.vx, rsp_vertex_x);
         compare_field("y", v.vy, rsp_vertex_y);
         compare_field("z", v.vz, rsp_vertex_z);
         compare_field("density", v.density, rsp_vertex_density);
         compare_field("last_of_run", v.last, rsp_last_of_run);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dim_x   = 1;
         dim_y   = 1;
         dim_z   = 1;
         enabled = 1'b1;
         cur_x   = 0;
         cur_y   = 0;
         cur_z   = 0;
         expected_vertices.delete();
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               vcva_pkg::CSR_DIM_X: begin
                  dim_x = effective_dim(csr_wdata, vcva_pkg::MAX_DIM_X);
               end
               vcva_pkg::CSR_DIM_Y: begin
                  dim_y = effective_dim(csr_wdata, vcva_pkg::MAX_DIM_Y);
               end
               vcva_pkg::CSR_DIM_Z: begin
                  dim_z = effective_dim(csr_wdata, vcva_pkg::MAX_DIM_Z);
               end
               vcva_pkg::CSR_ENABLE: begin
                  enabled = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) check_vertex();
         if (req_valid && req_ready) predict_vertices(req_cell_density, req_first_cell);
      end
      vertices_due   <= expected_vertices.size();
      mismatch_count <= errs;
   end

endmodule

/* verif/tb_voxel_cell_to_vertex_average.sv */
// Testbench top: drives cells and register writes into the averager and reports the verdict.
`timescale 1ns / 1ps

module tb_voxel_cell_to_vertex_average;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 100;
   localparam int RANDOM_ITEMS    = 500;
   localparam int FILL_DIM        = 4;
   localparam int FILL_CELLS      = FILL_DIM * FILL_DIM * 2;
   localparam logic [vcva_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [vcva_pkg::DENS_W-1:0]  req_cell_density = '0;
   logic                                req_first_cell = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [vcva_pkg::VTX_W-1:0]          rsp_vertex_x;
   logic [vcva_pkg::VTX_W-1:0]          rsp_vertex_y;
   logic [vcva_pkg::VTX_W-1:0]          rsp_vertex_z;
   logic signed [vcva_pkg::DENS_W-1:0]  rsp_vertex_density;
   logic                                rsp_last_of_run;
   logic                                csr_we = 1'b0;
   logic [vcva_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [vcva_pkg::CSR_DAT_W-1:0]      csr_wdata = '0;

   int   mismatch_count;
   int   vertices_due;
   logic no_idle = 1'b0;
   logic cur_enable = 1'b1;
   int   hold_requests = 0;
   int   scored_items = 0;
   int   idle_cycles = 0;

   always #5 clock = ~clock;

   voxel_cell_to_vertex_average u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cell_density   (req_cell_density),
      .req_first_cell     (req_first_cell),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_vertex_x       (rsp_vertex_x),
      .rsp_vertex_y       (rsp_vertex_y),
      .rsp_vertex_z       (rsp_vertex_z),
      .rsp_vertex_density (rsp_vertex_density),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   vertex_average_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cell_density   (req_cell_density),
      .req_first_cell     (req_first_cell),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_vertex_x       (rsp_vertex_x),
      .rsp_vertex_y       (rsp_vertex_y),
      .rsp_vertex_z       (rsp_vertex_z),
      .rsp_vertex_density (rsp_vertex_density),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .vertices_due       (vertices_due)
   );

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [vcva_pkg::DENS_W-1:0] random_density();
      unique case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return vcva_pkg::DENS_W'(int'($urandom_range(0, 7)) - 4);
         default: return vcva_pkg::DENS_W'($urandom());
      endcase
   endfunction

   function automatic int grid_extent(input int v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic int pick_dim();
      if ($urandom_range(0, 9) == 0) return 0;
      return $urandom_range(1, 4);
   endfunction

   task automatic send_cell(input logic signed [vcva_pkg::DENS_W-1:0] dens,
                            input logic first);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cell_density <= dens;
      req_first_cell   <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_run(input int n_cells, input int grid_cells, input bit broken);
      logic first;
      for (int i = 0; i < n_cells; i++) begin
         if (broken) begin
            first = ($urandom_range(0, 9) == 0);
         end else begin
            first = (i % grid_cells == 0);
         end
         send_cell(random_density(), first);
         if (cur_enable) scored_items++;
      end
   endtask

   task automatic write_csr(input logic [vcva_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vcva_pkg::CSR_DAT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input int wx, input int wy, input int wz, input logic en);
      write_csr(vcva_pkg::CSR_DIM_X, vcva_pkg::CSR_DAT_W'(wx));
      write_csr(vcva_pkg::CSR_DIM_Y, vcva_pkg::CSR_DAT_W'(wy));
      write_csr(vcva_pkg::CSR_DIM_Z, vcva_pkg::CSR_DAT_W'(wz));
      write_csr(vcva_pkg::CSR_ENABLE, {6'($urandom()), en});
      cur_enable = en;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (vertices_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int served;
      int burst;
      int gap;
      served = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_requests != served) begin
            served = hold_requests;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (burst) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int phase;
      int wx;
      int wy;
      int wz;
      int cells;
      logic en;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill both planes of the small-grid corner once, with output disabled
      no_idle = 1'b1;
      set_grid(FILL_DIM, FILL_DIM, 2, 1'b0);
      send_run(FILL_CELLS, FILL_CELLS, 1'b0);
      settle();
      no_idle = 1'b0;

      set_grid(2, 2, 2, 1'b1);
      for (int i = 0; i < 8; i++) send_cell(16'sh7FFF, i == 0);
      for (int i = 0; i < 8; i++) send_cell(16'sh8000, i == 0);
      settle();

      set_grid(0, 0, 0, 1'b1);
      send_cell(16'sh0001, 1'b1);
      send_cell(16'shFFFF, 1'b0);
      settle();

      // shrink x under a running position
      set_grid(3, 3, 2, 1'b1);
      for (int i = 0; i < 5; i++) send_cell(random_density(), i == 0);
      settle();
      write_csr(vcva_pkg::CSR_DIM_X, 7'd2);
      write_csr(CSR_SPARE, 7'h7F);
      for (int i = 0; i < 3; i++) send_cell(random_density(), 1'b0);
      settle();

      phase = 0;
      while (scored_items < RANDOM_ITEMS) begin
         wx = pick_dim();
         wy = pick_dim();
         wz = pick_dim();
         en = 1'b1;
         case (phase)
            0: begin
               wx = 127;
               wy = $urandom_range(1, 2);
               wz = 1;
            end
            1: begin
               wx = 1;
               wy = 64;
               wz = $urandom_range(1, 2);
            end
            2: begin
               wx = 1;
               wy = 1;
               wz = 100;
            end
            3: begin
               wx = 3;
               wy = 3;
               wz = 3;
            end
            default: begin
               en = ($urandom_range(0, 7) != 0);
            end
         endcase
         set_grid(wx, wy, wz, en);
         cells = grid_extent(wx) * grid_extent(wy) * grid_extent(wz);
         no_idle = (phase == 3) || ($urandom_range(0, 4) == 0);
         if (phase == 3) begin
            hold_requests++;
         end
         if (phase > 3 && $urandom_range(0, 5) == 0) begin
            send_run($urandom_range(1, 2 * cells), cells, 1'b1);
         end else begin
            send_run(cells * ((cells <= 32) ? $urandom_range(1, 3) : 1), cells, 1'b0);
         end
         settle();
         phase++;
      end
      no_idle = 1'b0;

      settle();
      if (mismatch_count == 0 && vertices_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/vcva_pkg.sv
rtl/vcva_plane_ram.sv
rtl/vcva_accum.sv
rtl/vcva_seq.sv
rtl/voxel_cell_to_vertex_average.sv
rtl/vcva_checker.sv
verif/vertex_average_checker.sv
verif/tb_voxel_cell_to_vertex_average.sv
